// File: hdl/tdam_pkg.sv
// ----------------------------------------------------------------------------
// tdam_pkg
// Shared types, constants and helpers for the time-of-day alarm matcher.
// ----------------------------------------------------------------------------
package tdam_pkg;

  localparam int unsigned RESYNC_TICKS = 30;

  localparam int unsigned RESYNC_W  = 5;
  localparam int unsigned TIME_W    = 7;
  localparam int unsigned WEEKDAY_W = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 12;
  localparam int unsigned START_W   = 11;

  localparam logic [TIME_W-1:0]    SECONDS_WRAP = TIME_W'(60);
  localparam logic [TIME_W-1:0]    MINUTES_WRAP = TIME_W'(60);
  localparam logic [TIME_W-1:0]    HOURS_WRAP   = TIME_W'(24);
  localparam logic [WEEKDAY_W-1:0] WEEKDAY_WRAP = WEEKDAY_W'(7);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MANUAL_MODE = 3'd0,
    CFG_SPORT_START = 3'd1,
    CFG_SLEEP_START = 3'd2,
    CFG_ALARM_ONE   = 3'd3,
    CFG_ALARM_TWO   = 3'd4
  } cfg_idx_t;

  // tens * 10 + units, digits taken as they stand
  function automatic logic [TIME_W-1:0] bcd_to_bin(input logic [2:0] tens,
                                                   input logic [3:0] units);
    bcd_to_bin = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0} + {3'b000, units};
  endfunction

endpackage

// File: hdl/time_of_day_alarm_matcher.sv
// ----------------------------------------------------------------------------
// time_of_day_alarm_matcher
// Keeps a binary time of day, loads it from clock-chip BCD bytes, advances it
// on one-second ticks and flags alarm or start-time matches.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle and its result appears in the output
// register on the next cycle; the time update and the alarm compares are one
// stage of logic between the time counters and that register, so the rate is
// one request per cycle for as long as the result side does not stall. Every
// tick request advances the resync counter and each thirtieth one reloads the
// time from its clock bytes instead of adding a second. Configuration writes
// take effect at once and are meant to be made while the block is idle.
module time_of_day_alarm_matcher (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [tdam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tdam_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  logic                                func,
  input  logic [7:0]                          clock_seconds_bcd,
  input  logic [7:0]                          clock_minutes_bcd,
  input  logic [7:0]                          clock_hours_bcd,
  input  logic [7:0]                          clock_weekday,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic                                vibrate,
  output logic [tdam_pkg::TIME_W-1:0]         now_hour,
  output logic [tdam_pkg::TIME_W-1:0]         now_minute,
  output logic [tdam_pkg::TIME_W-1:0]         now_second,
  output logic [tdam_pkg::WEEKDAY_W-1:0]      now_weekday
);

  logic                              manual_mode;
  logic [tdam_pkg::START_W-1:0]      sport_start;
  logic [tdam_pkg::START_W-1:0]      sleep_start;
  logic [tdam_pkg::CFG_W-1:0]        alarm_one;
  logic [tdam_pkg::CFG_W-1:0]        alarm_two;

  logic [tdam_pkg::RESYNC_W-1:0]     resync_count;
  logic [tdam_pkg::TIME_W-1:0]       second_count;
  logic [tdam_pkg::TIME_W-1:0]       minute_count;
  logic [tdam_pkg::TIME_W-1:0]       hour_count;
  logic [tdam_pkg::WEEKDAY_W-1:0]    weekday_count;

  logic [tdam_pkg::RESYNC_W-1:0]     resync_count_next;
  logic [tdam_pkg::TIME_W-1:0]       second_count_next;
  logic [tdam_pkg::TIME_W-1:0]       minute_count_next;
  logic [tdam_pkg::TIME_W-1:0]       hour_count_next;
  logic [tdam_pkg::WEEKDAY_W-1:0]    weekday_count_next;
  logic                              vibrate_next;

  logic [tdam_pkg::RESYNC_W-1:0]     resync_inc;
  logic [tdam_pkg::TIME_W-1:0]       sec_inc;
  logic [tdam_pkg::TIME_W-1:0]       min_inc;
  logic [tdam_pkg::TIME_W-1:0]       hour_inc;
  logic [tdam_pkg::WEEKDAY_W-1:0]    wday_inc;
  logic [tdam_pkg::TIME_W-1:0]       load_second;
  logic [tdam_pkg::TIME_W-1:0]       load_minute;
  logic [tdam_pkg::TIME_W-1:0]       load_hour;
  logic                              do_load;
  logic                              item_accept;

  assign item_stall  = result_valid & result_stall;
  assign item_accept = item_valid & ~item_stall;

  assign load_second = tdam_pkg::bcd_to_bin(clock_seconds_bcd[6:4], clock_seconds_bcd[3:0]);
  assign load_minute = tdam_pkg::bcd_to_bin(clock_minutes_bcd[6:4], clock_minutes_bcd[3:0]);
  assign load_hour   = tdam_pkg::bcd_to_bin({1'b0, clock_hours_bcd[5:4]},
                                            clock_hours_bcd[3:0]);

  assign resync_inc = resync_count + 1'b1;
  assign sec_inc    = second_count + 1'b1;
  assign min_inc    = minute_count + 1'b1;
  assign hour_inc   = hour_count + 1'b1;
  assign wday_inc   = weekday_count + 1'b1;

  always_comb begin
    resync_count_next  = resync_count;
    second_count_next  = second_count;
    minute_count_next  = minute_count;
    hour_count_next    = hour_count;
    weekday_count_next = weekday_count;
    do_load            = 1'b0;
    if (!func) begin
      do_load = 1'b1;
    end else if (resync_inc == tdam_pkg::RESYNC_W'(tdam_pkg::RESYNC_TICKS)) begin
      resync_count_next = '0;
      do_load           = 1'b1;
    end else begin
      resync_count_next = resync_inc;
      if (sec_inc != tdam_pkg::SECONDS_WRAP) begin
        second_count_next = sec_inc;
      end else begin
        second_count_next = '0;
        if (min_inc != tdam_pkg::MINUTES_WRAP) begin
          minute_count_next = min_inc;
        end else begin
          minute_count_next = '0;
          if (hour_inc != tdam_pkg::HOURS_WRAP) begin
            hour_count_next = hour_inc;
          end else begin
            hour_count_next    = '0;
            weekday_count_next = (wday_inc == tdam_pkg::WEEKDAY_WRAP) ? '0 : wday_inc;
          end
        end
      end
    end
    if (do_load) begin
      second_count_next  = load_second;
      minute_count_next  = load_minute;
      hour_count_next    = load_hour;
      weekday_count_next = clock_weekday[2:0];
    end
  end

  always_comb begin
    vibrate_next = 1'b0;
    if (!manual_mode) begin
      if (hour_count_next == {2'b00, sport_start[10:6]} &&
          minute_count_next == {1'b0, sport_start[5:0]}) begin
        vibrate_next = 1'b1;
      end
      if (hour_count_next == {2'b00, sleep_start[10:6]} &&
          minute_count_next == {1'b0, sleep_start[5:0]}) begin
        vibrate_next = 1'b1;
      end
    end
    if (alarm_one[11] && hour_count_next == {2'b00, alarm_one[10:6]} &&
        minute_count_next == {1'b0, alarm_one[5:0]}) begin
      vibrate_next = 1'b1;
    end
    if (alarm_two[11] && hour_count_next == {2'b00, alarm_two[10:6]} &&
        minute_count_next == {1'b0, alarm_two[5:0]}) begin
      vibrate_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      manual_mode <= 1'b1;
      sport_start <= '0;
      sleep_start <= '0;
      alarm_one   <= '0;
      alarm_two   <= '0;
    end else if (cfg_we) begin
      case (tdam_pkg::cfg_idx_t'(cfg_index))
        tdam_pkg::CFG_MANUAL_MODE: manual_mode <= cfg_data[0];
        tdam_pkg::CFG_SPORT_START: sport_start <= cfg_data[tdam_pkg::START_W-1:0];
        tdam_pkg::CFG_SLEEP_START: sleep_start <= cfg_data[tdam_pkg::START_W-1:0];
        tdam_pkg::CFG_ALARM_ONE:   alarm_one   <= cfg_data;
        tdam_pkg::CFG_ALARM_TWO:   alarm_two   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resync_count  <= '0;
      second_count  <= '0;
      minute_count  <= '0;
      hour_count    <= '0;
      weekday_count <= '0;
      result_valid  <= 1'b0;
    end else begin
      if (item_accept) begin
        resync_count  <= resync_count_next;
        second_count  <= second_count_next;
        minute_count  <= minute_count_next;
        hour_count    <= hour_count_next;
        weekday_count <= weekday_count_next;
        result_valid  <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted request
  always_ff @(posedge clk) begin
    if (item_accept) begin
      vibrate     <= vibrate_next;
      now_hour    <= hour_count_next;
      now_minute  <= minute_count_next;
      now_second  <= second_count_next;
      now_weekday <= weekday_count_next;
    end
  end

endmodule

// File: hdl/tdam_checker.sv
// ----------------------------------------------------------------------------
// tdam_checker
// Port-level checks for the time-of-day alarm matcher, bound to the top level.
// ----------------------------------------------------------------------------
module tdam_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             item_valid,
  input logic                             item_stall,
  input logic                             func,
  input logic [7:0]                       clock_seconds_bcd,
  input logic                             result_valid,
  input logic                             result_stall,
  input logic                             vibrate,
  input logic [tdam_pkg::TIME_W-1:0]      now_hour,
  input logic [tdam_pkg::TIME_W-1:0]      now_minute,
  input logic [tdam_pkg::TIME_W-1:0]      now_second,
  input logic [tdam_pkg::WEEKDAY_W-1:0]   now_weekday
);

  // a waiting result holds its payload
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(vibrate) &&
      $stable(now_hour) && $stable(now_minute) && $stable(now_second) &&
      $stable(now_weekday))
    else $error("stalled result changed");

  // no new request while the held result is still stalled
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |-> item_stall)
    else $error("request taken over a stalled result");

  // every accepted request gives a result in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> result_valid)
    else $error("accepted request gave no result");

  // a load request reports its decoded seconds
  assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall && !func |=>
      now_second == tdam_pkg::bcd_to_bin($past(clock_seconds_bcd[6:4]),
                                         $past(clock_seconds_bcd[3:0])))
    else $error("load request reported wrong seconds");

  // nothing is shown straight after reset
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind time_of_day_alarm_matcher tdam_checker u_tdam_checker (
  .clk               (clk),
  .rst               (rst),
  .item_valid        (item_valid),
  .item_stall        (item_stall),
  .func              (func),
  .clock_seconds_bcd (clock_seconds_bcd),
  .result_valid      (result_valid),
  .result_stall      (result_stall),
  .vibrate           (vibrate),
  .now_hour          (now_hour),
  .now_minute        (now_minute),
  .now_second        (now_second),
  .now_weekday       (now_weekday)
);

// File: bench/time_of_day_alarm_matcher_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// time_of_day_alarm_matcher_test
// Self-checking bench for the alarm matcher: a queue of clock-chip requests
// feeds a driver, a clocked monitor predicts each readout from its own copy
// of the time counters and settings and compares every field on arrival.
// Settings change between phases while the block is idle; both sides idle at
// random and the result side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module time_of_day_alarm_matcher_test;

  localparam int          RESYNC_PERIOD = 30;
  localparam int          NUM_PHASES    = 8;
  localparam int          PHASE_ITEMS   = 155;
  localparam int          LONG_HOLD     = 300;
  localparam int          CYCLE_LIMIT   = 500000;
  localparam logic        FUNC_LOAD     = 1'b0;
  localparam logic        FUNC_TICK     = 1'b1;

  typedef struct packed {
    logic       func;
    logic [7:0] sec_bcd;
    logic [7:0] min_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] wday_raw;
  } chip_request_t;

  typedef struct packed {
    logic                           vibrate;
    logic [tdam_pkg::TIME_W-1:0]    hour;
    logic [tdam_pkg::TIME_W-1:0]    minute;
    logic [tdam_pkg::TIME_W-1:0]    second;
    logic [tdam_pkg::WEEKDAY_W-1:0] weekday;
  } time_readout_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [tdam_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tdam_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           item_valid = 1'b0;
  logic                           item_stall;
  logic                           func = 1'b0;
  logic [7:0]                     clock_seconds_bcd = '0;
  logic [7:0]                     clock_minutes_bcd = '0;
  logic [7:0]                     clock_hours_bcd = '0;
  logic [7:0]                     clock_weekday = '0;
  logic                           result_valid;
  logic                           result_stall = 1'b0;
  logic                           vibrate;
  logic [tdam_pkg::TIME_W-1:0]    now_hour;
  logic [tdam_pkg::TIME_W-1:0]    now_minute;
  logic [tdam_pkg::TIME_W-1:0]    now_second;
  logic [tdam_pkg::WEEKDAY_W-1:0] now_weekday;

  time_of_day_alarm_matcher i_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .item_valid        (item_valid),
    .item_stall        (item_stall),
    .func              (func),
    .clock_seconds_bcd (clock_seconds_bcd),
    .clock_minutes_bcd (clock_minutes_bcd),
    .clock_hours_bcd   (clock_hours_bcd),
    .clock_weekday     (clock_weekday),
    .result_valid      (result_valid),
    .result_stall      (result_stall),
    .vibrate           (vibrate),
    .now_hour          (now_hour),
    .now_minute        (now_minute),
    .now_second        (now_second),
    .now_weekday       (now_weekday)
  );

  always #6 clk = ~clk;

  // predicted time counters and settings
  logic [tdam_pkg::RESYNC_W-1:0]  resync_cnt = '0;
  logic [tdam_pkg::TIME_W-1:0]    sec_cnt = '0;
  logic [tdam_pkg::TIME_W-1:0]    min_cnt = '0;
  logic [tdam_pkg::TIME_W-1:0]    hour_cnt = '0;
  logic [tdam_pkg::WEEKDAY_W-1:0] wday_cnt = '0;
  logic                           manual_set = 1'b1;
  logic [tdam_pkg::START_W-1:0]   sport_hm = '0;
  logic [tdam_pkg::START_W-1:0]   sleep_hm = '0;
  logic [tdam_pkg::CFG_W-1:0]     alarm_one_reg = '0;
  logic [tdam_pkg::CFG_W-1:0]     alarm_two_reg = '0;

  chip_request_t queued_requests[$];
  time_readout_t due_readouts[$];
  chip_request_t offered_request;
  time_readout_t got_readout;
  time_readout_t want_readout;

  logic item_taken = 1'b0;
  logic steady = 1'b0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   hold_left = 0;
  int   hold_asked = 0;
  int   hold_served = 0;
  int   cycle_count = 0;
  int   mismatch_count = 0;
  int   readout_count = 0;
  int   tick_total = 0;
  int   load_total = 0;
  int   reloads_seen = 0;
  int   vibrate_total = 0;
  int   settings_total = 0;

  function automatic void set_time_from_chip(input chip_request_t r);
    sec_cnt  = tdam_pkg::TIME_W'(int'(r.sec_bcd[6:4]) * 10 + int'(r.sec_bcd[3:0]));
    min_cnt  = tdam_pkg::TIME_W'(int'(r.min_bcd[6:4]) * 10 + int'(r.min_bcd[3:0]));
    hour_cnt = tdam_pkg::TIME_W'(int'(r.hour_bcd[5:4]) * 10 + int'(r.hour_bcd[3:0]));
    wday_cnt = r.wday_raw[2:0];
  endfunction

  function automatic logic hm_hit(input logic [tdam_pkg::START_W-1:0] hm);
    return hour_cnt == {2'b00, hm[10:6]} && min_cnt == {1'b0, hm[5:0]};
  endfunction

  function automatic time_readout_t advance_clock(input chip_request_t r);
    time_readout_t o;
    if (r.func == FUNC_LOAD) begin
      load_total++;
      set_time_from_chip(r);
    end else begin
      tick_total++;
      resync_cnt = resync_cnt + 1'b1;
      if (resync_cnt == tdam_pkg::RESYNC_W'(RESYNC_PERIOD)) begin
        resync_cnt = '0;
        reloads_seen++;
        set_time_from_chip(r);
      end else begin
        sec_cnt = sec_cnt + 1'b1;
        if (sec_cnt == tdam_pkg::SECONDS_WRAP) begin
          sec_cnt = '0;
          min_cnt = min_cnt + 1'b1;
          if (min_cnt == tdam_pkg::MINUTES_WRAP) begin
            min_cnt  = '0;
            hour_cnt = hour_cnt + 1'b1;
            if (hour_cnt == tdam_pkg::HOURS_WRAP) begin
              hour_cnt = '0;
              wday_cnt = wday_cnt + 1'b1;
              if (wday_cnt == tdam_pkg::WEEKDAY_WRAP) wday_cnt = '0;
            end
          end
        end
      end
    end
    o.vibrate = (!manual_set && (hm_hit(sport_hm) || hm_hit(sleep_hm)))
             || (alarm_one_reg[11] && hm_hit(alarm_one_reg[10:0]))
             || (alarm_two_reg[11] && hm_hit(alarm_two_reg[10:0]));
    o.hour    = hour_cnt;
    o.minute  = min_cnt;
    o.second  = sec_cnt;
    o.weekday = wday_cnt;
    if (o.vibrate) vibrate_total++;
    return o;
  endfunction

  function automatic chip_request_t raw_request(input logic f, input logic [7:0] s,
                                                input logic [7:0] m, input logic [7:0] h,
                                                input logic [7:0] w);
    chip_request_t r;
    r.func     = f;
    r.sec_bcd  = s;
    r.min_bcd  = m;
    r.hour_bcd = h;
    r.wday_raw = w;
    return r;
  endfunction

  // bcd digits with random flag bits in the places the block ignores
  function automatic logic [7:0] to_bcd(input int unsigned v, input logic [7:0] junk_mask);
    logic [7:0] b;
    b = 8'(((v / 10) << 4) | (v % 10));
    return b | (8'($urandom) & junk_mask);
  endfunction

  function automatic chip_request_t near_focus(input logic f, input int unsigned fh,
                                               input int unsigned fm);
    int unsigned s;
    int unsigned m;
    int unsigned h;
    int unsigned w;
    int unsigned pick;
    s = ($urandom_range(0, 99) < 60) ? $urandom_range(50, 59)
                                     : $urandom_range(0, 59);
    pick = $urandom_range(0, 9);
    if (pick < 2) m = $urandom_range(0, 59);
    else if (pick < 5) m = (fm + 59) % 60;
    else m = fm;
    h = ($urandom_range(0, 9) < 8) ? fh : $urandom_range(0, 23);
    w = ($urandom_range(0, 9) == 0) ? 7 : $urandom_range(0, 6);
    return raw_request(f, to_bcd(s, 8'h80), to_bcd(m, 8'h80), to_bcd(h, 8'hc0),
                       8'(w) | (8'($urandom) & 8'hf8));
  endfunction

  function automatic chip_request_t noise_request(input logic f);
    return raw_request(f, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic logic [tdam_pkg::START_W-1:0] pack_hm(input int unsigned h,
                                                           input int unsigned m);
    return {5'(h), 6'(m)};
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(input tdam_pkg::cfg_idx_t idx,
                           input logic [tdam_pkg::CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      tdam_pkg::CFG_MANUAL_MODE: manual_set = data[0];
      tdam_pkg::CFG_SPORT_START: sport_hm = data[tdam_pkg::START_W-1:0];
      tdam_pkg::CFG_SLEEP_START: sleep_hm = data[tdam_pkg::START_W-1:0];
      tdam_pkg::CFG_ALARM_ONE:   alarm_one_reg = data;
      tdam_pkg::CFG_ALARM_TWO:   alarm_two_reg = data;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // checked at the rising edge, where the request side is settled
  task automatic wait_idle();
    do @(posedge clk);
    while (queued_requests.size() != 0 || item_valid || due_readouts.size() != 0);
    @(negedge clk);
  endtask

  // loads followed by runs of ticks, long enough to pass resync points
  task automatic fill_phase(input int n, input int unsigned fh, input int unsigned fm);
    int pushed;
    int run;
    pushed = 0;
    while (pushed < n) begin
      queued_requests.push_back(($urandom_range(0, 99) < 80) ?
                                near_focus(FUNC_LOAD, fh, fm) : noise_request(FUNC_LOAD));
      pushed++;
      run = $urandom_range(1, 45);
      if (run > n - pushed) run = n - pushed;
      repeat (run) begin
        queued_requests.push_back(($urandom_range(0, 99) < 85) ?
                                  near_focus(FUNC_TICK, fh, fm) : noise_request(FUNC_TICK));
        pushed++;
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (item_valid && !item_taken) begin
      // stalled request holds
    end else if (gap_left > 0) begin
      gap_left--;
      item_valid <= 1'b0;
    end else if (queued_requests.size() != 0) begin
      offered_request = queued_requests.pop_front();
      func              <= offered_request.func;
      clock_seconds_bcd <= offered_request.sec_bcd;
      clock_minutes_bcd <= offered_request.min_bcd;
      clock_hours_bcd   <= offered_request.hour_bcd;
      clock_weekday     <= offered_request.wday_raw;
      item_valid        <= 1'b1;
      gap_left = pick_gap();
    end else begin
      item_valid <= 1'b0;
    end
  end

  // result side stalls
  always @(negedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served++;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else if (steady || $urandom_range(0, 99) < 65) begin
      result_stall <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                               : $urandom_range(0, 3);
      result_stall <= 1'b1;
    end
  end

  // readout monitor and prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        got_readout = '{vibrate, now_hour, now_minute, now_second, now_weekday};
        readout_count++;
        if (due_readouts.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("readout %0d arrived with nothing expected", readout_count);
        end else begin
          want_readout = due_readouts.pop_front();
          if (got_readout.vibrate !== want_readout.vibrate
              || got_readout.hour !== want_readout.hour
              || got_readout.minute !== want_readout.minute
              || got_readout.second !== want_readout.second
              || got_readout.weekday !== want_readout.weekday) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"readout %0d: expected vibrate %0d %0d:%0d:%0d day %0d, ",
                        "got vibrate %0d %0d:%0d:%0d day %0d"},
                       readout_count, want_readout.vibrate, want_readout.hour,
                       want_readout.minute, want_readout.second, want_readout.weekday,
                       got_readout.vibrate, got_readout.hour, got_readout.minute,
                       got_readout.second, got_readout.weekday);
          end
        end
      end
      if (item_valid && !item_stall) due_readouts.push_back(advance_clock(offered_request));
    end
    item_taken = !rst && item_valid && !item_stall;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("time_of_day_alarm_matcher_test NOT OK");
      $finish;
    end
  end

  initial begin
    int unsigned fh;
    int unsigned fm;
    logic        en_one;
    logic        en_two;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: carries, non-bcd digits, ignored bits, every match source
    write_reg(tdam_pkg::CFG_MANUAL_MODE, '0);
    write_reg(tdam_pkg::CFG_SPORT_START, {1'b0, pack_hm(23, 59)});
    write_reg(tdam_pkg::CFG_SLEEP_START, '0);
    write_reg(tdam_pkg::CFG_ALARM_ONE, {1'b1, pack_hm(12, 30)});
    write_reg(tdam_pkg::CFG_ALARM_TWO, 12'hfff);
    cfg_we <= 1'b0;
    settings_total++;
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h00, 8'h00, 8'h00, 8'h00));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'hff, 8'hff, 8'hff, 8'hff));
    queued_requests.push_back(raw_request(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h59, 8'h59, 8'h23, 8'h06));
    queued_requests.push_back(raw_request(FUNC_TICK, 8'h11, 8'h22, 8'h05, 8'h03));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h59, 8'h59, 8'h23, 8'h07));
    queued_requests.push_back(raw_request(FUNC_TICK, 8'hff, 8'hff, 8'hff, 8'hff));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h59, 8'h59, 8'h3f, 8'h02));
    queued_requests.push_back(raw_request(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h59, 8'h58, 8'h23, 8'h01));
    queued_requests.push_back(raw_request(FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h00, 8'h63, 8'h31, 8'h05));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h07, 8'h30, 8'h12, 8'h03));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h80, 8'h80, 8'hc0, 8'hf8));
    queued_requests.push_back(raw_request(FUNC_LOAD, 8'h0a, 8'h0f, 8'h0f, 8'h00));
    wait_idle();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      fh = (phase % 3 == 0) ? 23 : $urandom_range(0, 23);
      fm = (phase % 2 == 0) ? 59 : $urandom_range(0, 59);
      if (phase == 0) begin
        write_reg(tdam_pkg::CFG_MANUAL_MODE, '0);
        write_reg(tdam_pkg::CFG_SPORT_START, '0);
        write_reg(tdam_pkg::CFG_SLEEP_START, '0);
        write_reg(tdam_pkg::CFG_ALARM_ONE, '0);
        write_reg(tdam_pkg::CFG_ALARM_TWO, '0);
      end else if (phase == 1) begin
        write_reg(tdam_pkg::CFG_MANUAL_MODE, 12'hfff);
        write_reg(tdam_pkg::CFG_SPORT_START, 12'hfff);
        write_reg(tdam_pkg::CFG_SLEEP_START, 12'hfff);
        write_reg(tdam_pkg::CFG_ALARM_ONE, 12'hfff);
        write_reg(tdam_pkg::CFG_ALARM_TWO, 12'hfff);
      end else begin
        en_one = ($urandom_range(0, 3) != 0);
        en_two = ($urandom_range(0, 3) != 0);
        write_reg(tdam_pkg::CFG_MANUAL_MODE, 12'($urandom));
        write_reg(tdam_pkg::CFG_SPORT_START, ($urandom_range(0, 3) != 0) ?
                  {1'($urandom), pack_hm(fh, fm)} : 12'($urandom));
        write_reg(tdam_pkg::CFG_SLEEP_START, {1'($urandom), pack_hm(fh, (fm + 1) % 60)});
        write_reg(tdam_pkg::CFG_ALARM_ONE, {en_one, pack_hm(fh, fm)});
        write_reg(tdam_pkg::CFG_ALARM_TWO, {en_two, ($urandom_range(0, 1) != 0) ?
                                            pack_hm(fh, (fm + 1) % 60) : 11'($urandom)});
      end
      cfg_we <= 1'b0;
      settings_total++;
      steady = (phase == 2 || phase == 5);
      if (phase == 3) hold_asked++;
      fill_phase(PHASE_ITEMS, fh, fm);
      wait_idle();
    end

    repeat (4) @(posedge clk);
    mismatch_count += due_readouts.size();
    $display("requests: %0d loads, %0d ticks with %0d resync reloads, over %0d settings",
             load_total, tick_total, reloads_seen, settings_total);
    $display("readouts checked: %0d, of which %0d raised vibrate; mismatches: %0d",
             readout_count, vibrate_total, mismatch_count);
    if (mismatch_count == 0) begin
      $display("time_of_day_alarm_matcher_test OK");
    end else begin
      $display("time_of_day_alarm_matcher_test NOT OK");
    end
    $finish;
  end

endmodule
